// ----- src/gsig_pkg.sv -----
package gsig_pkg;

   // Widths of the result fields
   localparam int VIDX_W = 20;
   localparam int GRID_W = 10;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS    = 2'd1;

   // One emitted vertex
   typedef struct packed {
      logic [VIDX_W-1:0] linear_index;
      logic [GRID_W-1:0] grid_column;
      logic [GRID_W-1:0] grid_row;
      logic              bridge_vertex;
      logic              last_vertex;
   } vertex_type;

endpackage

// ----- src/gsig_csr.sv -----
module gsig_csr #(
   parameter int SEGMENT_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [gsig_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [SEGMENT_BITS-1:0]           csr_wdata,
   output logic [SEGMENT_BITS-1:0]           columns,
   output logic [SEGMENT_BITS-1:0]           rows
);

   logic [SEGMENT_BITS-1:0] columns_ff, columns_in;
   logic [SEGMENT_BITS-1:0] rows_ff, rows_in;
   logic [SEGMENT_BITS-1:0] wdata_eff;

   // Map a zero count to one segment
   assign wdata_eff = (csr_wdata == '0) ? SEGMENT_BITS'(1) : csr_wdata;

   // Decode the register index; other indexes are dropped
   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_valid) begin
         case (csr_index)
            gsig_pkg::REG_COLUMNS: columns_in = wdata_eff;
            gsig_pkg::REG_ROWS:    rows_in    = wdata_eff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= SEGMENT_BITS'(1);
         rows_ff    <= SEGMENT_BITS'(1);
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   assign columns = columns_ff;
   assign rows    = rows_ff;

endmodule

// ----- src/gsig_walk.sv -----
module gsig_walk #(
   parameter int SEGMENT_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    restart,
   input  logic [SEGMENT_BITS-1:0] columns,
   input  logic [SEGMENT_BITS-1:0] rows,
   output gsig_pkg::vertex_type    vertex
);

   localparam int PW = SEGMENT_BITS + 2;
   localparam int RW = SEGMENT_BITS + 1;
   localparam int MW = 2 * RW;
   localparam int VW = gsig_pkg::VIDX_W;
   localparam int GW = gsig_pkg::GRID_W;

   logic [SEGMENT_BITS-1:0] strip_ff, strip_in;
   logic [PW-1:0]           pos_ff, pos_in;

   logic [SEGMENT_BITS-1:0] s0, s;
   logic [PW-1:0]           p0, p, body, len0, p_inc;
   logic                    s0_last, s_last, stale, in_body, at_turn, last, wrap;
   logic [RW-1:0]           col_w, row_w, h_inc;
   logic [MW-1:0]           idx;

   // Apply restart, then fall back to the first vertex when the counters are stale
   assign s0      = restart ? '0 : strip_ff;
   assign p0      = restart ? '0 : pos_ff;
   assign body    = {1'b0, columns, 1'b0} + PW'(2);
   assign s0_last = (RW'(s0) + RW'(1)) == RW'(rows);
   assign len0    = s0_last ? body : body + PW'(2);
   assign stale   = (s0 >= rows) || (p0 >= len0);
   assign s       = stale ? '0 : s0;
   assign p       = stale ? '0 : p0;
   assign s_last  = (RW'(s) + RW'(1)) == RW'(rows);

   // Column and row: strip body alternates upper/lower, then two bridge vertices unless it is the last strip
   assign in_body = p < body;
   assign at_turn = p == body;
   always_comb begin
      if (in_body) begin
         col_w = p[PW-1:1];
         row_w = RW'(s) + RW'(p[0]);
      end else begin
         col_w = at_turn ? RW'(columns) : '0;
         row_w = RW'(s) + RW'(1);
      end
   end

   // Linear index row * (columns + 1) + column
   assign h_inc = RW'(columns) + RW'(1);
   assign idx   = MW'(row_w) * MW'(h_inc) + MW'(col_w);

   assign p_inc = p + PW'(1);
   assign last  = s_last && (p_inc == body);
   assign wrap  = p_inc == (body + PW'(2));

   always_comb begin
      vertex.linear_index  = VW'(idx);
      vertex.grid_column   = GW'(col_w);
      vertex.grid_row      = GW'(row_w);
      vertex.bridge_vertex = !in_body;
      vertex.last_vertex   = last;
   end

   // Advance the counters: wrap to the next strip, or back to the start
   always_comb begin
      strip_in = strip_ff;
      pos_in   = pos_ff;
      if (step) begin
         if (last) begin
            strip_in = '0;
            pos_in   = '0;
         end else if (wrap) begin
            strip_in = s + SEGMENT_BITS'(1);
            pos_in   = '0;
         end else begin
            strip_in = s;
            pos_in   = p_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= '0;
         pos_ff   <= '0;
      end else begin
         strip_ff <= strip_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ----- src/grid_strip_index_generator_core.sv -----
// Grid triangle-strip index generator. Each word accepted on req_ produces one vertex word
// on rsp_: column, row, linear index row*(columns+1)+column, a flag on the two degenerate
// vertices that join strips, and a flag on the final vertex of the plane; req_restart
// starts over at the first vertex. One word is taken every cycle while req_stall is low; a
// vertex passes through the input register, then the result register, and the path between
// them is set by the multiply of the row by columns+1. Write columns and rows through the
// csr_ port only while no word is in flight; a count of zero is taken as one.
module grid_strip_index_generator_core #(
   parameter int SEGMENT_BITS = 10
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_restart,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [gsig_pkg::VIDX_W-1:0]               rsp_linear_index,
   output logic [gsig_pkg::GRID_W-1:0]               rsp_grid_column,
   output logic [gsig_pkg::GRID_W-1:0]               rsp_grid_row,
   output logic                                      rsp_bridge_vertex,
   output logic                                      rsp_last_vertex,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [gsig_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [SEGMENT_BITS-1:0]                   csr_wdata
);

   localparam int GW = gsig_pkg::GRID_W;

   logic                    in_valid_ff, in_valid_in;
   logic                    in_restart_ff, in_restart_in;
   logic                    out_valid_ff, out_valid_in;
   gsig_pkg::vertex_type    out_ff, out_in;
   gsig_pkg::vertex_type    vertex;
   logic [SEGMENT_BITS-1:0] columns, rows;
   logic                    out_free, advance, req_take;

   gsig_csr #(.SEGMENT_BITS(SEGMENT_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .columns   (columns),
      .rows      (rows)
   );

   gsig_walk #(.SEGMENT_BITS(SEGMENT_BITS)) u_walk (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .restart (in_restart_ff),
      .columns (columns),
      .rows    (rows),
      .vertex  (vertex)
   );

   assign csr_ready = 1'b1;

   // Move a word from the input register to the result register when there is room
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Input register: load on accept, drop once moved on
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_restart_in = in_restart_ff;
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_restart_in = req_restart;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: load a new vertex, hold while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = vertex;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_restart_ff <= in_restart_in;
      out_ff        <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_linear_index  = out_ff.linear_index;
   assign rsp_grid_column   = out_ff.grid_column;
   assign rsp_grid_row      = out_ff.grid_row;
   assign rsp_bridge_vertex = out_ff.bridge_vertex;
   assign rsp_last_vertex   = out_ff.last_vertex;

   // The final vertex sits in a strip body, never on a bridge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bridge_vertex && rsp_last_vertex))
      else $error("last vertex flagged as bridge");

   // A bridge vertex is either the last column repeated or column zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bridge_vertex |->
         (rsp_grid_column == '0) || (rsp_grid_column == GW'(columns)))
      else $error("bridge vertex at an inner column");

   // An accepted word is in the input register on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted word lost");

   // A word that moves on always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("vertex not loaded into result register");

endmodule
